// ===== rtl/sfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, constants and the fade curve function of the screen fade
// sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int TIME_BITS  = 32;
  localparam int EASE_STEPS = 256;   // power of two: the step index is a quotient bit string
  localparam int IDX_W      = $clog2(EASE_STEPS);
  localparam int DIV_STEPS  = IDX_W;
  localparam int CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CFG_W      = 16;
  localparam int CODE_W     = 8;
  localparam int LEVEL_W    = 10;
  localparam int KIND_W     = 3;
  localparam int PHASE_W    = 3;
  localparam int ALU_W      = (TIME_BITS > CFG_W + 1) ? TIME_BITS : CFG_W + 1;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 10'd1023;

  localparam logic [CFG_W-1:0]  HALF_RESET    = 16'd500;
  localparam logic [CFG_W-1:0]  HOLD_RESET    = 16'd200;
  localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 16'd5000;
  localparam logic [CODE_W-1:0] OFF_RESET     = 8'd0;
  localparam logic [CODE_W-1:0] STARTUP_RESET = 8'd1;

  // q30 constants for the raised-cosine table
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] TWO_Q31     = 64'd2147483648;
  localparam logic [63:0] TAYLOR_DEN [6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_BRIGHT = 3'd1,
    KIND_SCREEN = 3'd2,
    KIND_HEART  = 3'd3,
    KIND_RENDER = 3'd4
  } kind_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_OUT  = 3'd1,
    PH_WAIT = 3'd2,
    PH_HOLD = 3'd3,
    PH_IN   = 3'd4
  } phase_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HALF    = 3'd0,
    REG_HOLD    = 3'd1,
    REG_TIMEOUT = 3'd2,
    REG_OFF     = 3'd3,
    REG_STARTUP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]  half;
    logic [CFG_W-1:0]  hold;
    logic [CFG_W-1:0]  timeout;
    logic [CODE_W-1:0] off_code;
    logic [CODE_W-1:0] startup_code;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

  // backlight level at one curve step, evaluated at elaboration only
  function automatic logic [LEVEL_W-1:0] ease_level(input int unsigned idx,
                                                     input logic rising);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] u;
    logic [63:0] prod;
    longint      sum;
    logic        neg;
    a = (64'(idx) * PI_Q30) / EASE_STEPS;
    if (a > PI_Q30) a = PI_Q30;
    neg = 1'b0;
    r = a;
    if (a > HALF_PI_Q30) begin
      r = PI_Q30 - a;
      neg = 1'b1;
    end
    x2 = (r * r) >> 30;
    term = ONE_Q30;
    sum = longint'(ONE_Q30);
    for (int k = 0; k < 6; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[k];
      if (k[0] == 1'b0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    if (neg) u = ONE_Q30 - 64'(sum);
    else u = ONE_Q30 + 64'(sum);
    if (rising) u = TWO_Q31 - u;
    prod = 64'(FULL_LEVEL) * u;
    return LEVEL_W'(prod >> 31);
  endfunction

endpackage

// ===== rtl/sfs_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_alu
// Shared subtractor: elapsed time, limit compares and divider steps.
// ----------------------------------------------------------------------------
module sfs_alu import sfs_pkg::*; (
  input  logic [ALU_W-1:0] op_a,
  input  logic [ALU_W-1:0] op_b,
  output alu_res_t         res
);

  logic [ALU_W:0] wide;

  assign wide       = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff   = wide[ALU_W-1:0];
  assign res.borrow = wide[ALU_W];

endmodule

// ===== rtl/sfs_ease_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ease_rom
// Raised-cosine fade table, down and up curves, registered read.
// ----------------------------------------------------------------------------
module sfs_ease_rom import sfs_pkg::*; (
  input  logic               clk,
  input  logic [IDX_W-1:0]   idx,
  input  logic               rising,
  output logic [LEVEL_W-1:0] level
);

  logic [LEVEL_W-1:0] dn_tab [EASE_STEPS];
  logic [LEVEL_W-1:0] up_tab [EASE_STEPS];
  logic [LEVEL_W-1:0] level_r;

  for (genvar g = 0; g < EASE_STEPS; g++) begin : g_tab
    localparam logic [LEVEL_W-1:0] DN = ease_level(g, 1'b0);
    localparam logic [LEVEL_W-1:0] UP = ease_level(g, 1'b1);
    assign dn_tab[g] = DN;
    assign up_tab[g] = UP;
  end

  always_ff @(posedge clk) begin
    level_r <= rising ? up_tab[idx] : dn_tab[idx];
  end

  assign level = level_r;

endmodule

// ===== rtl/sfs_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_regs
// APB-style configuration registers: fade, hold and timeout times, codes.
// ----------------------------------------------------------------------------
module sfs_regs import sfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half         <= HALF_RESET;
      cfg_r.hold         <= HOLD_RESET;
      cfg_r.timeout      <= TIMEOUT_RESET;
      cfg_r.off_code     <= OFF_RESET;
      cfg_r.startup_code <= STARTUP_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_HALF:    cfg_r.half         <= pwdata[CFG_W-1:0];
        REG_HOLD:    cfg_r.hold         <= pwdata[CFG_W-1:0];
        REG_TIMEOUT: cfg_r.timeout      <= pwdata[CFG_W-1:0];
        REG_OFF:     cfg_r.off_code     <= pwdata[CODE_W-1:0];
        REG_STARTUP: cfg_r.startup_code <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_HALF:    prdata = DATA_W'(cfg_r.half);
      REG_HOLD:    prdata = DATA_W'(cfg_r.hold);
      REG_TIMEOUT: prdata = DATA_W'(cfg_r.timeout);
      REG_OFF:     prdata = DATA_W'(cfg_r.off_code);
      REG_STARTUP: prdata = DATA_W'(cfg_r.startup_code);
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/screen_fade_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_fade_sequencer
// Backlight fade sequencer for screen changes, built around one shared
// subtractor under a small sequencer.
//
// Input words (in_kind, in_screen_code) are ticks, brightness updates, screen
// requests, heartbeats and render passes; each gives one result word with the
// backlight level, the shown screen and the fade phase after that word.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce this. Tick, screen, heartbeat, unused
// kinds and updates in idle or waiting load go straight to the commit step;
// render passes and updates in hold black or at the end of a fade first take
// the elapsed time and a compare, and an update inside a fade then also runs
// the 8-step restoring divider for the curve index and the registered table read.
// in_ready rises again the cycle after the result is loaded, so the block
// takes no new word before the last one has been committed. A waiting result
// does not block the work on the next word; a stalled receiver holds the
// sequencer only in its final commit step. Reset (synchronous, rst_n low)
// clears the clock, phase and flags, shows the startup screen and loads the register defaults.
// ----------------------------------------------------------------------------
module screen_fade_sequencer import sfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CODE_W-1:0]  in_screen_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] out_pwm_level,
  output logic [CODE_W-1:0]  out_current_screen,
  output logic [PHASE_W-1:0] out_phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ELAP = 6'b000010,
    S_CMP  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ROM  = 6'b010000,
    S_FIN  = 6'b100000
  } seq_t;

  cfg_t cfg;

  seq_t               state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [CODE_W-1:0]  code_r;
  logic [TIME_BITS-1:0] el_r;
  logic               cmp_r;
  logic [CFG_W-1:0]   rem_r;
  logic [IDX_W-1:0]   q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;

  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] hb_r, hb_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CODE_W-1:0]  shown_r, shown_nxt;
  logic [CODE_W-1:0]  pending_r, pending_nxt;
  logic               loaded_r, loaded_nxt;
  logic [LEVEL_W-1:0] bright_r, bright_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b;
  alu_res_t           alu;
  logic [LEVEL_W-1:0] rom_level;
  logic               accept, commit, fading, need_time, need_div;

  sfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfs_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu)
  );

  sfs_ease_rom u_rom (
    .clk    (clk),
    .idx    (q_r),
    .rising (phase_r == PH_IN),
    .level  (rom_level)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign fading   = (phase_r == PH_OUT) || (phase_r == PH_IN);

  // words that need an elapsed time before they can commit
  assign need_time = (in_kind == KIND_RENDER) ||
                     ((in_kind == KIND_BRIGHT) && (fading || (phase_r == PH_HOLD)));
  assign need_div  = (kind_r == KIND_BRIGHT) && fading && alu.borrow;

  // shared unit operand select
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_ELAP: begin
        alu_a = ALU_W'(clock_r);
        alu_b = (kind_r == KIND_RENDER) ? ALU_W'(hb_r) : ALU_W'(start_r);
      end
      S_CMP: begin
        if (kind_r == KIND_RENDER) begin
          // borrow means silence longer than the timeout
          alu_a = ALU_W'(cfg.timeout);
          alu_b = ALU_W'(el_r);
        end else begin
          alu_a = ALU_W'(el_r);
          alu_b = (phase_r == PH_HOLD) ? ALU_W'(cfg.hold) : ALU_W'(cfg.half);
        end
      end
      S_DIV: begin
        alu_a = ALU_W'({rem_r, 1'b0});
        alu_b = ALU_W'(cfg.half);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = need_time ? S_ELAP : S_FIN;
      S_ELAP: state_nxt = S_CMP;
      S_CMP:  state_nxt = need_div ? S_DIV : S_FIN;
      S_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_ROM;
      S_ROM:  state_nxt = S_FIN;
      S_FIN:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      code_r <= in_screen_code;
    end
    if (state_r == S_ELAP) el_r <= alu.diff[TIME_BITS-1:0];
    if (state_r == S_CMP) begin
      cmp_r <= (kind_r == KIND_RENDER) ? alu.borrow : !alu.borrow;
      rem_r <= el_r[CFG_W-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_DIV) begin
      if (!alu.borrow) rem_r <= alu.diff[CFG_W-1:0];
      else rem_r <= alu_a[CFG_W-1:0];
      q_r   <= {q_r[IDX_W-2:0], !alu.borrow};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // architectural update for the word in hand
  always_comb begin
    clock_nxt   = clock_r;
    start_nxt   = start_r;
    hb_nxt      = hb_r;
    phase_nxt   = phase_r;
    shown_nxt   = shown_r;
    pending_nxt = pending_r;
    loaded_nxt  = loaded_r;
    bright_nxt  = bright_r;
    case (kind_r)
      KIND_TICK: clock_nxt = clock_r + 1'b1;
      KIND_BRIGHT: begin
        case (phase_r)
          PH_OUT: begin
            if (cmp_r) begin
              shown_nxt  = pending_r;
              bright_nxt = '0;
              phase_nxt  = PH_WAIT;
            end else begin
              bright_nxt = rom_level;
            end
          end
          PH_WAIT: begin
            bright_nxt = '0;
            if (loaded_r) begin
              start_nxt = clock_r;
              phase_nxt = PH_HOLD;
            end
          end
          PH_HOLD: begin
            bright_nxt = '0;
            if (cmp_r) begin
              start_nxt = clock_r;
              phase_nxt = PH_IN;
            end
          end
          PH_IN: begin
            if (cmp_r) begin
              bright_nxt  = FULL_LEVEL;
              phase_nxt   = PH_IDLE;
              pending_nxt = '0;
            end else begin
              bright_nxt = rom_level;
            end
          end
          default: bright_nxt = (shown_r == cfg.off_code) ? '0 : FULL_LEVEL;
        endcase
      end
      KIND_SCREEN: begin
        if (code_r != shown_r) begin
          pending_nxt = code_r;
          start_nxt   = clock_r;
          phase_nxt   = PH_OUT;
          loaded_nxt  = 1'b0;
        end
      end
      KIND_HEART: hb_nxt = clock_r;
      KIND_RENDER: begin
        if (cmp_r) shown_nxt = cfg.startup_code;
        if (phase_r == PH_WAIT) loaded_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r   <= '0;
      start_r   <= '0;
      hb_r      <= '0;
      phase_r   <= PH_IDLE;
      shown_r   <= STARTUP_RESET;
      pending_r <= '0;
      loaded_r  <= 1'b0;
      bright_r  <= '0;
    end else if (commit) begin
      clock_r   <= clock_nxt;
      start_r   <= start_nxt;
      hb_r      <= hb_nxt;
      phase_r   <= phase_nxt;
      shown_r   <= shown_nxt;
      pending_r <= pending_nxt;
      loaded_r  <= loaded_nxt;
      bright_r  <= bright_nxt;
    end
  end

  // state only moves on commit, which waits for a free output, so it is the result word
  assign out_valid          = out_valid_r;
  assign out_pwm_level      = bright_r;
  assign out_current_screen = shown_r;
  assign out_phase          = phase_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("sequencer ready right after taking a word");

  a_rem_below_half: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < cfg.half))
    else $error("divider remainder reached the half time");

  a_div_only_fading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ((phase_r == PH_OUT) || (phase_r == PH_IN)))
    else $error("divider running outside a fade");

  a_black_phases: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_WAIT) || (phase_r == PH_HOLD)) |-> (bright_r == '0))
    else $error("backlight on while waiting load or holding black");

endmodule

// ===== test/backlight_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlight_checker
// Passive watcher for the screen fade sequencer. It follows register writes
// on the APB port, runs its own copy of the fade state for every accepted
// input word and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module backlight_checker import sfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CODE_W-1:0]  in_screen_code,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEVEL_W-1:0] out_pwm_level,
  input  logic [CODE_W-1:0]  out_current_screen,
  input  logic [PHASE_W-1:0] out_phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 mismatches,
  output int                 outstanding
);

  // pi and friends in q30
  localparam logic [63:0] PI_FIX      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;
  localparam logic [63:0] ONE_FIX     = 64'd1 << 30;
  localparam logic [63:0] TWO_FIX     = 64'd1 << 31;
  localparam int          CURVE_STEPS = 256;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CODE_W-1:0]  screen;
    logic [PHASE_W-1:0] phase;
  } backlight_t;

  backlight_t backlight_due[$];

  logic [CFG_W-1:0]  half_ms, hold_ms, hb_limit_ms;
  logic [CODE_W-1:0] off_code, boot_code;

  logic [31:0]        now_ms, fade_start_ms, heard_ms;
  phase_t             stage;
  logic [CODE_W-1:0]  shown, queued;
  logic               loaded;
  logic [LEVEL_W-1:0] level;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // raised-cosine level at one curve step, taylor series to the 12th power
  function automatic logic [LEVEL_W-1:0] curve_level(input logic [63:0] step,
                                                      input logic rising);
    logic [63:0] ang, r, x2, term, u;
    longint      acc;
    logic        neg;
    ang = (step * PI_FIX) / 64'(CURVE_STEPS);
    if (ang > PI_FIX) ang = PI_FIX;
    neg = (ang > HALF_PI_FIX);
    r = neg ? PI_FIX - ang : ang;
    x2 = (r * r) >> 30;
    term = ONE_FIX;
    acc = longint'(ONE_FIX);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_FIX)) acc = longint'(ONE_FIX);
    u = neg ? ONE_FIX - 64'(acc) : ONE_FIX + 64'(acc);
    if (rising) u = TWO_FIX - u;
    return LEVEL_W'((64'd1023 * u) >> 31);
  endfunction

  function automatic logic [LEVEL_W-1:0] fade_point(input logic [31:0] el,
                                                     input logic rising);
    return curve_level((64'(el) * 64'(CURVE_STEPS)) / 64'(half_ms), rising);
  endfunction

  task automatic apply_word(input logic [KIND_W-1:0] kind,
                            input logic [CODE_W-1:0] code);
    logic [31:0] el;
    logic [31:0] silence;
    el = now_ms - fade_start_ms;
    silence = now_ms - heard_ms;
    case (kind)
      KIND_TICK: now_ms = now_ms + 32'd1;
      KIND_BRIGHT: begin
        case (stage)
          PH_OUT: begin
            if (el >= {16'd0, half_ms}) begin
              shown = queued;
              level = '0;
              stage = PH_WAIT;
            end else begin
              level = fade_point(el, 1'b0);
            end
          end
          PH_WAIT: begin
            level = '0;
            if (loaded) begin
              fade_start_ms = now_ms;
              stage = PH_HOLD;
            end
          end
          PH_HOLD: begin
            level = '0;
            if (el >= {16'd0, hold_ms}) begin
              fade_start_ms = now_ms;
              stage = PH_IN;
            end
          end
          PH_IN: begin
            if (el >= {16'd0, half_ms}) begin
              level = FULL_LEVEL;
              stage = PH_IDLE;
              queued = '0;
            end else begin
              level = fade_point(el, 1'b1);
            end
          end
          default: level = (shown == off_code) ? '0 : FULL_LEVEL;
        endcase
      end
      KIND_SCREEN: begin
        // asking for the screen already shown does nothing
        if (code != shown) begin
          queued = code;
          fade_start_ms = now_ms;
          stage = PH_OUT;
          loaded = 1'b0;
        end
      end
      KIND_HEART: heard_ms = now_ms;
      KIND_RENDER: begin
        if (silence > {16'd0, hb_limit_ms}) shown = boot_code;
        if (stage == PH_WAIT) loaded = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    backlight_t want;
    backlight_t fresh;
    if (!rst_n) begin
      half_ms = HALF_RESET;
      hold_ms = HOLD_RESET;
      hb_limit_ms = TIMEOUT_RESET;
      off_code = OFF_RESET;
      boot_code = STARTUP_RESET;
      now_ms = '0;
      fade_start_ms = '0;
      heard_ms = '0;
      stage = PH_IDLE;
      shown = STARTUP_RESET;
      queued = '0;
      loaded = 1'b0;
      level = '0;
      backlight_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (backlight_due.size() == 0) begin
          flag_mismatch("result word with nothing expected", 32'(out_pwm_level), 32'd0);
        end else begin
          want = backlight_due.pop_front();
          if (out_pwm_level !== want.level)
            flag_mismatch("pwm_level", 32'(out_pwm_level), 32'(want.level));
          if (out_current_screen !== want.screen)
            flag_mismatch("current_screen", 32'(out_current_screen), 32'(want.screen));
          if (out_phase !== want.phase)
            flag_mismatch("phase", 32'(out_phase), 32'(want.phase));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_HALF:    half_ms = pwdata[CFG_W-1:0];
          REG_HOLD:    hold_ms = pwdata[CFG_W-1:0];
          REG_TIMEOUT: hb_limit_ms = pwdata[CFG_W-1:0];
          REG_OFF:     off_code = pwdata[CODE_W-1:0];
          REG_STARTUP: boot_code = pwdata[CODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        apply_word(in_kind, in_screen_code);
        fresh.level = level;
        fresh.screen = shown;
        fresh.phase = stage;
        backlight_due.push_back(fresh);
      end
    end
    outstanding = backlight_due.size();
  end

endmodule

// ===== test/screen_fade_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_fade_sequencer_tb
// Drives the screen fade sequencer with a short directed walk through every
// phase and corner case, then with many register settings and random screen
// changes built from ticks, updates, heartbeats and render passes, under random stalls
// on both channels. Checking is done by backlight_checker.
// ----------------------------------------------------------------------------
module screen_fade_sequencer_tb;
  import sfs_pkg::*;

  // word kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  // register slots past the last real register
  localparam int SPARE_REG_A = 5;
  localparam int SPARE_REG_B = 7;
  localparam int STRETCH_CYCLES = 80;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind;
  logic [CODE_W-1:0]  in_screen_code;
  logic               out_valid;
  logic               out_ready;
  logic [LEVEL_W-1:0] out_pwm_level;
  logic [CODE_W-1:0]  out_current_screen;
  logic [PHASE_W-1:0] out_phase;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int sent_words = 0;
  int stretch_req = 0;
  logic quiet = 1'b0;
  logic [CODE_W-1:0] off_sel = OFF_RESET;
  logic [CODE_W-1:0] boot_sel = STARTUP_RESET;

  screen_fade_sequencer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_screen_code(in_screen_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pwm_level(out_pwm_level), .out_current_screen(out_current_screen),
    .out_phase(out_phase),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  backlight_checker fade_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_screen_code(in_screen_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pwm_level(out_pwm_level), .out_current_screen(out_current_screen),
    .out_phase(out_phase),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // result side: random short stalls plus requested long hold-offs
  initial begin
    int seen;
    int hold;
    seen = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stretch_req != seen) begin
        seen = stretch_req;
        out_ready = 1'b0;
        repeat (STRETCH_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 4);
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_screen_code = code;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (kind <= KIND_RENDER) sent_words++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] hold,
                              input logic [CFG_W-1:0] limit, input logic [CODE_W-1:0] off,
                              input logic [CODE_W-1:0] boot);
    write_reg(REG_HALF, DATA_W'(half));
    write_reg(REG_HOLD, DATA_W'(hold));
    write_reg(REG_TIMEOUT, DATA_W'(limit));
    write_reg(REG_OFF, DATA_W'(off));
    write_reg(REG_STARTUP, DATA_W'(boot));
    off_sel = off;
    boot_sel = boot;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0: return off_sel;
      1: return boot_sel;
      2: return CODE_W'($urandom_range(0, 3));
      default: return CODE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one screen change followed by the usual mix of ticks, updates and renders
  task automatic run_transition();
    int len;
    int r;
    len = $urandom_range(10, 40);
    send_word(KIND_SCREEN, pick_code());
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_word(KIND_TICK, CODE_W'($urandom_range(0, 255)));
      else if (r < 80) send_word(KIND_BRIGHT, CODE_W'($urandom_range(0, 255)));
      else if (r < 92) send_word(KIND_RENDER, CODE_W'($urandom_range(0, 255)));
      else send_word(KIND_HEART, CODE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    int guard;
    int noise;
    logic [CFG_W-1:0] half_pick, hold_pick, limit_pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_TICK;
    in_screen_code = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // register defaults after reset
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_SPARE_LO, 8'h00);
    send_word(KIND_SPARE_HI, 8'hFF);
    send_word(KIND_SCREEN, STARTUP_RESET);
    send_word(KIND_RENDER, 8'h00);
    settle();

    // writes past the register map must not land anywhere
    write_reg(SPARE_REG_A, 32'hFFFF_FFFF);
    write_reg(SPARE_REG_B, 32'hFFFF_FFFF);
    program_regs(16'd0, 16'd0, 16'd0, 8'h00, 8'h01);

    // zero fade time: each fade ends at its first update
    send_word(KIND_SCREEN, 8'hAA);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_RENDER, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_SCREEN, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    // new request mid-change, then a heartbeat timeout while not idle
    send_word(KIND_SCREEN, 8'h55);
    send_word(KIND_TICK, 8'h00);
    send_word(KIND_RENDER, 8'h00);
    send_word(KIND_HEART, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_RENDER, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);
    send_word(KIND_BRIGHT, 8'h00);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        1: program_regs(16'd1, 16'd0, 16'd0, 8'h00, 8'h00);
        default: begin
          case ($urandom_range(0, 9))
            0: half_pick = 16'd0;
            7, 8: half_pick = CFG_W'($urandom_range(5, 40));
            9: half_pick = CFG_W'($urandom_range(0, 65535));
            default: half_pick = CFG_W'($urandom_range(1, 4));
          endcase
          hold_pick = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                   : CFG_W'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: limit_pick = 16'd0;
            1: limit_pick = CFG_W'($urandom_range(0, 65535));
            default: limit_pick = CFG_W'($urandom_range(1, 30));
          endcase
          program_regs(half_pick, hold_pick, limit_pick, pick_code(),
                       CODE_W'($urandom_range(0, 255)));
        end
      endcase
      quiet = (ph >= 10);
      // block fills up while results are held back
      if (ph == 3 || ph == 7) stretch_req++;
      target = sent_words + 75;
      while (sent_words < target) begin
        if ($urandom_range(0, 9) < 6) begin
          run_transition();
        end else begin
          noise = $urandom_range(1, 5);
          repeat (noise)
            send_word(KIND_W'($urandom_range(0, 7)), CODE_W'($urandom_range(0, 255)));
        end
      end
    end

    in_valid = 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (30) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
